>>> rtl/fpc_pkg.sv
// shared types, constants and codes for the fixed point 2d convolution block
package fpc_pkg;

  localparam int MAX_KERNEL = 5;
  localparam int MAX_WIDTH  = 1024;

  localparam int PIX_W    = 16;
  localparam int PROD_W   = 2 * PIX_W;
  localparam int PSUM_W   = PROD_W + $clog2(MAX_KERNEL + 1);
  localparam int TOT_W    = PSUM_W + $clog2(MAX_KERNEL + 1);
  localparam int ADDR_W   = $clog2(MAX_WIDTH);
  localparam int KIDX_W   = $clog2(MAX_KERNEL + 1);
  localparam int OUT_W    = 28;

  // request codes
  localparam logic REQ_COEF  = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_KERNEL_SIZE  = 2'd2;

  typedef logic signed [PIX_W-1:0] fpc_pix_t;
  typedef logic [ADDR_W-1:0] fpc_addr_t;
  typedef logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][PIX_W-1:0] fpc_win_t;
  typedef logic [MAX_KERNEL-2:0][PIX_W-1:0] fpc_line_t;

  typedef struct packed {
    logic              req_type;
    logic [2:0]        coef_row;
    logic [2:0]        coef_col;
    logic signed [15:0] coef_value;
    logic signed [15:0] pixel_value;
  } fpc_in_t;

  typedef struct packed {
    logic signed [27:0] out_value;
    logic [15:0]        out_row;
    logic [9:0]         out_col;
    logic               frame_last;
  } fpc_out_t;

  // result tag travelling with a pixel through the mac pipeline
  typedef struct packed {
    logic        vld;
    logic        last;
    logic [15:0] row;
    logic [9:0]  col;
  } fpc_tag_t;

  // coefficient write travelling in order with the pixels
  typedef struct packed {
    logic        vld;
    logic [2:0]  row;
    logic [2:0]  col;
    logic signed [15:0] value;
  } fpc_coef_wr_t;

endpackage

>>> rtl/fpc_window.sv
// line store memory with read-modify-write forwarding and the pixel window
module fpc_window (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             pix_acc,
  input  fpc_pkg::fpc_pix_t  pix_in,
  input  fpc_pkg::fpc_addr_t addr_in,
  output fpc_pkg::fpc_win_t  win
);
  import fpc_pkg::*;

  fpc_line_t mem [MAX_WIDTH];

  logic      s1_vld_r;
  logic      fwd_r;
  fpc_pix_t  s1_pix_r;
  fpc_addr_t s1_addr_r;
  fpc_line_t rd_data_r;
  fpc_line_t fwd_data_r;
  fpc_line_t line;
  fpc_line_t wr_word;
  fpc_pix_t  col [MAX_KERNEL];
  fpc_win_t  win_r;

  // column vector: stored rows oldest first, new pixel last
  always_comb begin
    line = fwd_r ? fwd_data_r : rd_data_r;
    for (int j = 0; j < MAX_KERNEL - 1; j++) begin
      col[j] = line[j];
    end
    col[MAX_KERNEL-1] = s1_pix_r;
    for (int j = 0; j < MAX_KERNEL - 1; j++) begin
      wr_word[j] = col[j+1];
    end
  end

  // line store read at accept, written back from stage one
  always_ff @(posedge clk) begin
    if (adv) begin
      rd_data_r <= mem[addr_in];
      if (s1_vld_r) begin
        mem[s1_addr_r] <= wr_word;
      end
    end
  end

  // stage one control and forwarding of a same-entry write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      fwd_r    <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= pix_acc;
      fwd_r    <= pix_acc && s1_vld_r && (addr_in == s1_addr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pix_r   <= pix_in;
      s1_addr_r  <= addr_in;
      fwd_data_r <= wr_word;
    end
  end

  // window shifts left, new column enters at the right
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (adv && s1_vld_r) begin
      for (int i = 0; i < MAX_KERNEL; i++) begin
        for (int t = 0; t < MAX_KERNEL - 1; t++) begin
          win_r[i][t] <= win_r[i][t+1];
        end
        win_r[i][MAX_KERNEL-1] <= col[i];
      end
    end
  end

  assign win = win_r;

endmodule

>>> rtl/fpc_mac.sv
// coefficient store, parallel multiply lanes, adder tree and rounding
module fpc_mac (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic [2:0]           k,
  input  fpc_pkg::fpc_coef_wr_t coef_wr,
  input  fpc_pkg::fpc_tag_t     tag_in,
  input  fpc_pkg::fpc_win_t     win,
  output logic                 out_valid,
  output fpc_pkg::fpc_out_t     out_data
);
  import fpc_pkg::*;

  logic signed [PIX_W-1:0]  coef_r [MAX_KERNEL][MAX_KERNEL];
  logic signed [PROD_W-1:0] prod_nxt [MAX_KERNEL][MAX_KERNEL];
  logic signed [PROD_W-1:0] prod_r [MAX_KERNEL][MAX_KERNEL];
  logic signed [PSUM_W-1:0] psum_nxt [MAX_KERNEL];
  logic signed [PSUM_W-1:0] psum_r [MAX_KERNEL];
  logic signed [TOT_W-1:0]  tot_nxt;
  logic signed [TOT_W-1:0]  tot_r;
  logic [TOT_W:0]           mag;
  logic [TOT_W:0]           rnd;
  logic [TOT_W:0]           q;
  logic [KIDX_W-1:0]        off;
  fpc_tag_t                 s2_tag_r, s3_tag_r, s4_tag_r, s5_tag_r;
  logic                     out_valid_r;
  fpc_out_t                 out_data_r;

  assign off = KIDX_W'(MAX_KERNEL) - KIDX_W'(k);

  // coefficient store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_KERNEL; i++) begin
        for (int t = 0; t < MAX_KERNEL; t++) begin
          coef_r[i][t] <= '0;
        end
      end
    end else if (adv && coef_wr.vld) begin
      for (int i = 0; i < MAX_KERNEL; i++) begin
        for (int t = 0; t < MAX_KERNEL; t++) begin
          if (coef_wr.row == 3'(i) && coef_wr.col == 3'(t)) begin
            coef_r[i][t] <= coef_wr.value;
          end
        end
      end
    end
  end

  // one multiplier per window position; window (j,m) meets coef (m-off, j-off)
  always_comb begin
    logic [KIDX_W-1:0] ci;
    logic [KIDX_W-1:0] ti;
    for (int j = 0; j < MAX_KERNEL; j++) begin
      for (int m = 0; m < MAX_KERNEL; m++) begin
        ci = KIDX_W'(m) - off;
        ti = KIDX_W'(j) - off;
        if (KIDX_W'(j) >= off && KIDX_W'(m) >= off) begin
          prod_nxt[j][m] = $signed(coef_r[ci][ti]) * $signed(win[j][m]);
        end else begin
          prod_nxt[j][m] = '0;
        end
      end
    end
  end

  // row partial sums
  always_comb begin
    for (int j = 0; j < MAX_KERNEL; j++) begin
      psum_nxt[j] = '0;
      for (int m = 0; m < MAX_KERNEL; m++) begin
        psum_nxt[j] = psum_nxt[j] + PSUM_W'(prod_r[j][m]);
      end
    end
  end

  // total
  always_comb begin
    tot_nxt = '0;
    for (int j = 0; j < MAX_KERNEL; j++) begin
      tot_nxt = tot_nxt + TOT_W'(psum_r[j]);
    end
  end

  // divide by 256, round half away from zero
  always_comb begin
    mag = tot_r[TOT_W-1] ? -{tot_r[TOT_W-1], tot_r} : {tot_r[TOT_W-1], tot_r};
    rnd = (mag + (TOT_W+1)'(128)) >> 8;
    q   = tot_r[TOT_W-1] ? -rnd : rnd;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_nxt;
      psum_r <= psum_nxt;
      tot_r  <= tot_nxt;
      out_data_r.out_value  <= q[OUT_W-1:0];
      out_data_r.out_row    <= s5_tag_r.row;
      out_data_r.out_col    <= s5_tag_r.col;
      out_data_r.frame_last <= s5_tag_r.last;
    end
  end

  // tag pipeline and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_tag_r    <= '0;
      s3_tag_r    <= '0;
      s4_tag_r    <= '0;
      s5_tag_r    <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s2_tag_r    <= tag_in;
      s3_tag_r    <= s2_tag_r;
      s4_tag_r    <= s3_tag_r;
      s5_tag_r    <= s4_tag_r;
      out_valid_r <= s5_tag_r.vld;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/fixed_point_conv2d_top.sv
// top level of the fixed point 2d convolution block: config, counters, pipeline control
//
// config port: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 is image width,
//   1 image height, 2 kernel size. cfg_ready is always high; write only while idle.
// input channel: in_valid/in_stall carrying one in_data beat. a coefficient beat loads
//   the kernel, a pixel beat enters the raster stream.
// output channel: out_valid/out_stall carrying one out_data beat per pixel whose window
//   lies fully inside the frame; frame_last marks the last one of a frame.
// timing: one beat per cycle sustained while no result is held by out_stall. a result
//   is offered after line store read at the accepting edge, window update, multiply,
//   row sums, total and rounding. each pixel reads and writes back the line store
//   entry of its column through separate ports; same-entry back-to-back is forwarded.
// reset: synchronous active low; coefficients, window and counters clear, registers
//   return to width 1024, height 1024, kernel 3. the line store is not cleared.
// stall: when out_valid is held by out_stall the whole pipeline freezes and in_stall
//   rises in the same cycle; nothing is lost.
module fixed_point_conv2d_top (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  fpc_pkg::fpc_in_t  in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output fpc_pkg::fpc_out_t out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data
);
  import fpc_pkg::*;

  logic [10:0]  image_width_r;
  logic [15:0]  image_height_r;
  logic [2:0]   kernel_size_r;
  logic [10:0]  eff_w;
  logic [15:0]  eff_h;
  logic [2:0]   eff_k;
  logic [9:0]   col_count_r;
  logic [15:0]  row_count_r;
  logic         adv;
  logic         acc;
  logic         acc_pix;
  logic         col_end;
  logic         row_end;
  logic         emit;
  fpc_tag_t     s1_tag_r;
  fpc_coef_wr_t s1_cw_r;
  fpc_win_t     win;

  assign adv       = !out_valid || !out_stall;
  assign in_stall  = !adv;
  assign acc       = in_valid && adv;
  assign acc_pix   = acc && (in_data.req_type == REQ_PIXEL);
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= 11'd1024;
      image_height_r <= 16'd1024;
      kernel_size_r  <= 3'd3;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width_r  <= cfg_data[10:0];
        CFG_IMAGE_HEIGHT: image_height_r <= cfg_data;
        CFG_KERNEL_SIZE:  kernel_size_r  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // effective limits
  always_comb begin
    if (image_width_r == '0) eff_w = 11'd1;
    else if (image_width_r > 11'(MAX_WIDTH)) eff_w = 11'(MAX_WIDTH);
    else eff_w = image_width_r;
    eff_h = (image_height_r == '0) ? 16'd1 : image_height_r;
    if (kernel_size_r == '0) eff_k = 3'd1;
    else if (kernel_size_r > 3'(MAX_KERNEL)) eff_k = 3'(MAX_KERNEL);
    else eff_k = kernel_size_r;
  end

  assign col_end = ({1'b0, col_count_r} + 11'd1) >= eff_w;
  assign row_end = ({1'b0, row_count_r} + 17'd1) >= {1'b0, eff_h};
  assign emit    = (({1'b0, col_count_r} + 11'd1) >= 11'(eff_k)) &&
                   (({1'b0, row_count_r} + 17'd1) >= 17'(eff_k));

  // raster counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= '0;
      row_count_r <= '0;
    end else if (acc_pix) begin
      if (col_end) begin
        col_count_r <= '0;
        row_count_r <= row_end ? 16'd0 : row_count_r + 16'd1;
      end else begin
        col_count_r <= col_count_r + 10'd1;
      end
    end
  end

  // stage one: result tag and coefficient write, in beat order
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r <= '0;
      s1_cw_r  <= '0;
    end else if (adv) begin
      s1_tag_r.vld   <= acc_pix && emit;
      s1_tag_r.last  <= col_end && row_end;
      s1_tag_r.row   <= row_count_r + 16'd1 - 16'(eff_k);
      s1_tag_r.col   <= col_count_r + 10'd1 - 10'(eff_k);
      s1_cw_r.vld    <= acc && (in_data.req_type == REQ_COEF) &&
                        (in_data.coef_row < 3'(MAX_KERNEL)) &&
                        (in_data.coef_col < 3'(MAX_KERNEL));
      s1_cw_r.row    <= in_data.coef_row;
      s1_cw_r.col    <= in_data.coef_col;
      s1_cw_r.value  <= in_data.coef_value;
    end
  end

  fpc_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .pix_acc (acc_pix),
    .pix_in  (in_data.pixel_value),
    .addr_in (ADDR_W'(col_count_r)),
    .win     (win)
  );

  fpc_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .k         (eff_k),
    .coef_wr   (s1_cw_r),
    .tag_in    (s1_tag_r),
    .win       (win),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // input is held back only by a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a blocked result");

  // a new result only appears when the pipeline moved
  a_out_from_adv: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(adv))
    else $error("result appeared on a frozen pipeline");

  // coefficient beats leave the raster position alone
  a_coef_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_data.req_type == REQ_COEF) |=>
      (col_count_r == $past(col_count_r) && row_count_r == $past(row_count_r)))
    else $error("coefficient beat moved the counters");

endmodule

>>> tb/tb_fixed_point_conv2d_top.sv
// testbench for the fixed point 2d convolution block: predicted pixel stream checked beat by beat
module tb_fixed_point_conv2d_top;
  import fpc_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  fpc_in_t in_data;
  logic out_valid;
  logic out_stall;
  fpc_out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  fixed_point_conv2d_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  int unsigned img_w, img_h, ksize;
  logic signed [15:0] line_mem [MAX_KERNEL][MAX_WIDTH];
  logic signed [15:0] win [MAX_KERNEL][MAX_KERNEL];
  logic signed [15:0] kern [MAX_KERNEL][MAX_KERNEL];
  int unsigned row_cnt, col_cnt;

  fpc_in_t pending_beats[$];
  fpc_out_t expected_pixels[$];
  int errors;
  int n_px, n_coef, n_out, n_frames;
  bit in_gaps, out_gaps;
  bit hold_out;
  int hold_cycles;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // compute expected result of one accepted beat
  task automatic predict_beat(input fpc_in_t b);
    logic signed [15:0] colv [MAX_KERNEL];
    longint acc, q;
    int unsigned c, r, off;
    bit emit, last;
    fpc_out_t e;
    if (b.req_type == REQ_COEF) begin
      if (b.coef_row < MAX_KERNEL && b.coef_col < MAX_KERNEL)
        kern[b.coef_row][b.coef_col] = b.coef_value;
      return;
    end
    c = (col_cnt >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_cnt;
    r = row_cnt;
    for (int i = 0; i < MAX_KERNEL - 1; i++) colv[i] = line_mem[i][c];
    colv[MAX_KERNEL-1] = b.pixel_value;
    for (int i = 0; i < MAX_KERNEL - 1; i++) line_mem[i][c] = colv[i+1];
    for (int i = 0; i < MAX_KERNEL; i++) begin
      for (int t = 0; t < MAX_KERNEL - 1; t++) win[i][t] = win[i][t+1];
      win[i][MAX_KERNEL-1] = colv[i];
    end
    emit = (col_cnt + 1 >= ksize) && (row_cnt + 1 >= ksize);
    last = (col_cnt + 1 >= img_w) && (row_cnt + 1 >= img_h);
    if (col_cnt + 1 >= img_w) begin
      col_cnt = 0;
      row_cnt = (row_cnt + 1 >= img_h) ? 0 : row_cnt + 1;
    end else begin
      col_cnt = col_cnt + 1;
    end
    if (!emit) return;
    off = MAX_KERNEL - ksize;
    acc = 0;
    for (int i = 0; i < ksize; i++)
      for (int t = 0; t < ksize; t++)
        acc += longint'(kern[i][t]) * longint'(win[off+t][off+i]);
    // round half away from zero
    if (acc >= 0) q = (acc + 128) >>> 8;
    else q = -((-acc + 128) >>> 8);
    e.out_value = q[27:0];
    e.out_row = 16'(r + 1 - ksize);
    e.out_col = 10'(c + 1 - ksize);
    e.frame_last = last;
    expected_pixels.push_back(e);
  endtask

  // driver: offer queued beats, predict on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_beat(in_data);
        if (in_data.req_type == REQ_PIXEL) n_px++;
        else n_coef++;
      end
      if (!(in_valid && in_stall)) begin
        if (pending_beats.size() > 0 && !(in_gaps && $urandom_range(99) < 30)) begin
          in_valid <= 1'b1;
          in_data <= pending_beats.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare results and drive receiver stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected result beat %p", out_data);
          errors++;
        end else begin
          fpc_out_t e;
          e = expected_pixels.pop_front();
          n_out++;
          if (out_data.frame_last) n_frames++;
          if (out_data.out_value !== e.out_value) begin
            $error("out_value expected %0d actual %0d", e.out_value, out_data.out_value);
            errors++;
          end
          if (out_data.out_row !== e.out_row) begin
            $error("out_row expected %0d actual %0d", e.out_row, out_data.out_row);
            errors++;
          end
          if (out_data.out_col !== e.out_col) begin
            $error("out_col expected %0d actual %0d", e.out_col, out_data.out_col);
            errors++;
          end
          if (out_data.frame_last !== e.frame_last) begin
            $error("frame_last expected %0d actual %0d", e.frame_last, out_data.frame_last);
            errors++;
          end
        end
      end
      // long hold-off counted here
      if (hold_out && hold_cycles == 0) hold_cycles = 60;
      if (hold_cycles > 0) begin
        hold_cycles--;
        if (hold_cycles == 0) hold_out = 1'b0;
        out_stall <= 1'b1;
      end else begin
        out_stall <= out_gaps && ($urandom_range(99) < 30);
      end
    end
  end

  // watchdog on accepted beats
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_beats.size() > 0 || in_valid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_IMAGE_WIDTH: img_w = (val[10:0] < 1) ? 1 : (val[10:0] > MAX_WIDTH) ? MAX_WIDTH
                               : val[10:0];
      CFG_IMAGE_HEIGHT: img_h = (val == 0) ? 1 : val;
      default: ksize = (val[2:0] < 1) ? 1 : (val[2:0] > MAX_KERNEL) ? MAX_KERNEL : val[2:0];
    endcase
  endtask

  function automatic fpc_in_t coef_beat(int r, int c, logic signed [15:0] v);
    fpc_in_t b;
    b = '0;
    b.req_type = REQ_COEF;
    b.coef_row = r[2:0];
    b.coef_col = c[2:0];
    b.coef_value = v;
    b.pixel_value = 16'($urandom);
    return b;
  endfunction

  function automatic fpc_in_t pixel_beat(logic signed [15:0] v);
    fpc_in_t b;
    logic [63:0] noise;
    noise = {$urandom, $urandom};
    b = noise[$bits(fpc_in_t)-1:0];
    b.req_type = REQ_PIXEL;
    b.pixel_value = v;
    return b;
  endfunction

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom_range(511)) - 16'sd256;
      default: return 16'($urandom);
    endcase
  endfunction

  // whole kernel load then full frames
  task automatic queue_frames(int w, int h, int k, int frames);
    for (int a = 0; a < MAX_KERNEL; a++)
      for (int b = 0; b < MAX_KERNEL; b++)
        pending_beats.push_back(coef_beat(a, b, rand_sample()));
    // an out of range index is ignored
    pending_beats.push_back(coef_beat($urandom_range(7, 5), $urandom_range(7), 16'($urandom)));
    for (int f = 0; f < frames * w * h; f++)
      pending_beats.push_back(pixel_beat(rand_sample()));
  endtask

  task automatic run_phase(int w, int h, int k, int frames);
    write_reg(CFG_IMAGE_WIDTH, 16'(w));
    write_reg(CFG_IMAGE_HEIGHT, 16'(h));
    write_reg(CFG_KERNEL_SIZE, 16'(k));
    queue_frames(w, h, k, frames);
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_IMAGE_WIDTH;
    cfg_data = '0;
    errors = 0;
    in_gaps = 1'b0;
    out_gaps = 1'b0;
    hold_out = 1'b0;
    hold_cycles = 0;
    img_w = 1024; img_h = 1024; ksize = 3;
    row_cnt = 0; col_cnt = 0;
    foreach (win[i, j]) begin
      win[i][j] = '0;
      kern[i][j] = '0;
    end
    foreach (line_mem[i, j]) line_mem[i][j] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, rounding, tiny frames, kernel bigger than frame
    write_reg(CFG_IMAGE_WIDTH, 16'd3);
    write_reg(CFG_IMAGE_HEIGHT, 16'd3);
    write_reg(CFG_KERNEL_SIZE, 16'd1);
    pending_beats.push_back(coef_beat(0, 0, 16'sh0080));
    pending_beats.push_back(pixel_beat(16'sd1));
    pending_beats.push_back(pixel_beat(-16'sd1));
    pending_beats.push_back(pixel_beat(16'sd3));
    pending_beats.push_back(pixel_beat(-16'sd3));
    pending_beats.push_back(pixel_beat(16'sh7fff));
    pending_beats.push_back(pixel_beat(16'sh8000));
    pending_beats.push_back(coef_beat(0, 0, 16'sh8000));
    pending_beats.push_back(pixel_beat(16'sh8000));
    pending_beats.push_back(pixel_beat(16'sh7fff));
    pending_beats.push_back(pixel_beat(16'sh0000));
    wait_drained();
    run_phase(2, 2, 3, 1);
    run_phase(1, 1, 1, 2);
    run_phase(5, 5, 5, 1);

    // random phases with idling both sides
    in_gaps = 1'b1;
    out_gaps = 1'b1;
    for (int p = 0; p < 3; p++)
      run_phase($urandom_range(1, 12), $urandom_range(1, 8), $urandom_range(1, 5), 1);
    run_phase(1024, 1, 1, 1);
    run_phase(3, 1, 1, 2);

    // long hold-off while the sender keeps going
    hold_out = 1'b1;
    run_phase(8, 8, 3, 2);

    // stretch with no idling
    in_gaps = 1'b0;
    out_gaps = 1'b0;
    run_phase(16, 6, 4, 2);
    in_gaps = 1'b1;
    out_gaps = 1'b1;
    run_phase(7, 9, 2, 1);

    $display("covered %0d pixel beats, %0d coefficient beats", n_px, n_coef);
    $display("checked %0d results across %0d completed frames", n_out, n_frames);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
